FILE: rtl/core/rgbcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbcf_pkg;

   localparam int COLOR_BITS_DEFAULT = 8;
   localparam int FRAME_BITS_DEFAULT = 16;

   localparam int FADE_BITS     = 16;
   localparam int LIMIT_BITS    = 8;
   localparam int FIELD_BITS    = 8;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_BITS      = 32;
   localparam int RSP_BITS      = 32;
   localparam int CHANNELS      = 3;
   localparam int AVG_DIVISOR   = 3;

   localparam logic [CSR_ADDR_BITS-1:0] REG_FADE_FRAMES = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_RED_LIMIT   = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_GREEN_LIMIT = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BLUE_LIMIT  = 2'd3;

   localparam logic [FADE_BITS-1:0]  FADE_RESET  = 16'd100;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'hFF;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_MUL,
      UNIT_DIV
   } unit_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_AVG_WAIT,
      ST_CHECK,
      ST_BLEND,
      ST_BLEND_WAIT,
      ST_FINISH
   } core_state_type;

   typedef struct packed {
      logic start;
      logic scale;  // 1: multiply opa by opb before dividing
   } unit_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/rgb_random_color_crossfade_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Random-color crossfade for a three-channel RGB lamp. Each req transaction is one frame
// tick (enable level plus a candidate color) and yields exactly one rsp transaction with
// the three duty values and status flags. While enabled, duties move linearly from the
// start color to the target color over fade_frames ticks; at the end of a fade, or on
// light-up, the candidate becomes the new target if it passes the brightness-window and
// spread test, and otherwise the tick is skipped and candidate_rejected is set.
// Disabling drives black. The average and the three channel blends share one bit-serial
// multiply/divide unit, one bit per cycle. A fading tick runs the three channel blends; a
// restart first runs the average and the check, a rejected tick ends after the check, and
// a disabled tick goes straight to the result. A new tick is taken while the last result
// still waits in the output register; the following result then waits until that one is
// taken.
module rgb_random_color_crossfade_core
   import rgbcf_pkg::*;
#(
   parameter int COLOR_BITS = COLOR_BITS_DEFAULT,
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,

   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // led_enable[0], candidate_red[8:1], candidate_green[16:9], candidate_blue[24:17]
   input  wire logic [REQ_BITS-1:0]      req_tdata,

   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // red_duty[7:0], green_duty[15:8], blue_duty[23:16], lamp_lit[24],
   // target_taken[25], candidate_rejected[26]
   output logic [RSP_BITS-1:0]           rsp_tdata
);

   localparam int CMPW = (FRAME_BITS > FADE_BITS) ? FRAME_BITS : FADE_BITS;
   localparam int SUMW = COLOR_BITS + 2;

   core_state_type          state_ff, state_in;

   logic [FADE_BITS-1:0]    fade_ff;
   logic [LIMIT_BITS-1:0]   red_lim_ff;
   logic [LIMIT_BITS-1:0]   green_lim_ff;
   logic [LIMIT_BITS-1:0]   blue_lim_ff;

   logic [COLOR_BITS-1:0]   cand_ff   [CHANNELS];
   logic [COLOR_BITS-1:0]   start_ff  [CHANNELS];
   logic [COLOR_BITS-1:0]   target_ff [CHANNELS];
   logic [COLOR_BITS-1:0]   drive_ff  [CHANNELS];
   logic [FRAME_BITS-1:0]   pos_ff;
   logic [FADE_BITS-1:0]    len_ff;
   logic [1:0]              ch_ff;
   logic                    lit_ff;
   logic                    taken_ff;
   logic                    rejected_ff;
   logic                    rsp_valid_ff;
   logic [RSP_BITS-1:0]     rsp_data_ff;

   logic                    accept;
   logic                    req_en;
   logic [COLOR_BITS-1:0]   req_cand [CHANNELS];
   logic [FADE_BITS-1:0]    fade_len;
   logic                    restart;
   logic                    rsp_load;
   logic                    rsp_free;

   logic [SUMW-1:0]         total;
   logic [COLOR_BITS-1:0]   lim [CHANNELS];
   logic [CHANNELS-1:0]     spread;
   logic                    in_window;
   logic                    spread_ok;
   logic                    cand_ok;

   logic [COLOR_BITS-1:0]   blend_from;
   logic [COLOR_BITS-1:0]   blend_to;
   logic                    blend_up;
   logic [COLOR_BITS-1:0]   blend_diff;
   logic [COLOR_BITS-1:0]   blend_result;

   unit_cmd_type            unit_cmd;
   logic [SUMW-1:0]         unit_opa;
   logic [FADE_BITS-1:0]    unit_div;
   logic                    unit_done;
   logic [COLOR_BITS-1:0]   unit_quo;

   assign req_en      = req_tdata[0];
   assign req_cand[0] = COLOR_BITS'(req_tdata[8:1]);
   assign req_cand[1] = COLOR_BITS'(req_tdata[16:9]);
   assign req_cand[2] = COLOR_BITS'(req_tdata[24:17]);

   assign accept   = req_tvalid && req_tready;
   assign fade_len = (fade_ff == '0) ? FADE_BITS'(1) : fade_ff;
   assign restart  = !lit_ff || (CMPW'(pos_ff) >= CMPW'(fade_len));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // candidate test
   assign total     = SUMW'(cand_ff[0]) + SUMW'(cand_ff[1]) + SUMW'(cand_ff[2]);
   assign lim[0]    = COLOR_BITS'(red_lim_ff);
   assign lim[1]    = COLOR_BITS'(green_lim_ff);
   assign lim[2]    = COLOR_BITS'(blue_lim_ff);
   assign in_window = (total > SUMW'(lim[1])) && (total <= (SUMW'(lim[1]) << 1));

   always_comb begin
      spread = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (unit_quo >= cand_ff[i]) begin
            spread[i] = (unit_quo - cand_ff[i]) > (lim[i] >> 1);
         end else begin
            spread[i] = (cand_ff[i] - unit_quo) > (lim[i] >> 1);
         end
      end
   end

   assign spread_ok = spread[0] || spread[1] || spread[2];
   assign cand_ok   = in_window && spread_ok;

   // channel blend operands
   assign blend_from   = start_ff[ch_ff];
   assign blend_to     = target_ff[ch_ff];
   assign blend_up     = (blend_to >= blend_from);
   assign blend_diff   = blend_up ? (blend_to - blend_from) : (blend_from - blend_to);
   assign blend_result = blend_up ? (blend_from + unit_quo) : (blend_from - unit_quo);

   assign unit_opa = (state_ff == ST_AVG) ? total : SUMW'(blend_diff);
   assign unit_div = (state_ff == ST_AVG) ? FADE_BITS'(AVG_DIVISOR) : len_ff;

   rgbcf_serial_unit #(
      .COLOR_BITS (COLOR_BITS),
      .FRAME_BITS (FRAME_BITS)
   ) u_serial (
      .clock    (clock),
      .reset    (reset),
      .cmd      (unit_cmd),
      .opa      (unit_opa),
      .opb      (pos_ff),
      .divisor  (unit_div),
      .done     (unit_done),
      .quotient (unit_quo)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_en) begin
                  state_in = ST_FINISH;
               end else if (restart) begin
                  state_in = ST_AVG;
               end else begin
                  state_in = ST_BLEND;
               end
            end
         end
         ST_AVG:      state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (unit_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:    state_in = cand_ok ? ST_BLEND : ST_FINISH;
         ST_BLEND:    state_in = ST_BLEND_WAIT;
         ST_BLEND_WAIT: begin
            if (unit_done) begin
               state_in = (ch_ff == 2'(CHANNELS - 1)) ? ST_FINISH : ST_BLEND;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      unit_cmd.start = (state_ff == ST_AVG) || (state_ff == ST_BLEND);
      unit_cmd.scale = (state_ff == ST_BLEND);
      rsp_load       = (state_ff == ST_FINISH) && rsp_free;
      rsp_tvalid     = rsp_valid_ff;
      rsp_tdata      = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fade_ff      <= FADE_RESET;
         red_lim_ff   <= LIMIT_RESET;
         green_lim_ff <= LIMIT_RESET;
         blue_lim_ff  <= LIMIT_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            start_ff[i]  <= '0;
            target_ff[i] <= '0;
            drive_ff[i]  <= '0;
         end
         pos_ff       <= '0;
         lit_ff       <= 1'b0;
         ch_ff        <= '0;
         taken_ff     <= 1'b0;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_addr)
               REG_FADE_FRAMES: fade_ff      <= csr_wdata;
               REG_RED_LIMIT:   red_lim_ff   <= csr_wdata[LIMIT_BITS-1:0];
               REG_GREEN_LIMIT: green_lim_ff <= csr_wdata[LIMIT_BITS-1:0];
               REG_BLUE_LIMIT:  blue_lim_ff  <= csr_wdata[LIMIT_BITS-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            taken_ff    <= 1'b0;
            rejected_ff <= 1'b0;
            ch_ff       <= '0;
            if (!req_en && lit_ff) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  target_ff[i] <= '0;
                  drive_ff[i]  <= '0;
               end
               lit_ff <= 1'b0;
            end
         end

         if (state_ff == ST_CHECK) begin
            if (cand_ok) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  start_ff[i]  <= target_ff[i];
                  target_ff[i] <= cand_ff[i];
               end
               pos_ff   <= '0;
               lit_ff   <= 1'b1;
               taken_ff <= 1'b1;
            end else begin
               rejected_ff <= 1'b1;
            end
         end

         if ((state_ff == ST_BLEND_WAIT) && unit_done) begin
            drive_ff[ch_ff] <= blend_result;
            if (ch_ff == 2'(CHANNELS - 1)) begin
               pos_ff <= pos_ff + FRAME_BITS'(1);
            end else begin
               ch_ff <= ch_ff + 2'd1;
            end
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < CHANNELS; i++) begin
            cand_ff[i] <= req_cand[i];
         end
         len_ff <= fade_len;
      end
      if (rsp_load) begin
         rsp_data_ff <= {5'b0, rejected_ff, taken_ff, lit_ff,
                         FIELD_BITS'(drive_ff[2]), FIELD_BITS'(drive_ff[1]),
                         FIELD_BITS'(drive_ff[0])};
      end
   end

   a_dark_when_off: assert property (@(posedge clock) disable iff (reset)
      !lit_ff |-> (drive_ff[0] == '0 && drive_ff[1] == '0 && drive_ff[2] == '0))
      else $error("drive color not black while lamp is off");

   a_unit_done_waited: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (state_ff == ST_AVG_WAIT || state_ff == ST_BLEND_WAIT))
      else $error("serial unit finished outside a wait state");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[25] && rsp_tdata[26]))
      else $error("target taken and candidate rejected in one transaction");

   a_taken_lit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> rsp_tdata[24])
      else $error("target taken while lamp not lit");

   a_disable_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tdata[0]) |=> !lit_ff)
      else $error("disabled tick left lamp lit");

endmodule

`default_nettype wire

FILE: rtl/core/rgbcf_serial_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial shift-add multiplier followed by a restoring divider.
// quotient = low COLOR_BITS bits of (opa * opb) / divisor, or opa / divisor without scale.
module rgbcf_serial_unit
   import rgbcf_pkg::*;
#(
   parameter int COLOR_BITS = COLOR_BITS_DEFAULT,
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire unit_cmd_type          cmd,
   input  wire logic [COLOR_BITS+1:0] opa,
   input  wire logic [FRAME_BITS-1:0] opb,
   input  wire logic [FADE_BITS-1:0]  divisor,
   output logic                       done,
   output logic [COLOR_BITS-1:0]      quotient
);

   localparam int PW = COLOR_BITS + FRAME_BITS + 2;
   localparam int CW = $clog2(PW);

   unit_phase_type          phase_ff, phase_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [PW-1:0]           mcand_ff, mcand_in;
   logic [FRAME_BITS-1:0]   mplier_ff, mplier_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic [FADE_BITS-1:0]    div_ff, div_in;
   logic [FADE_BITS-1:0]    rem_ff, rem_in;
   logic [COLOR_BITS-1:0]   quo_ff, quo_in;
   logic                    done_ff, done_in;

   logic                    last;
   logic [FADE_BITS:0]      trial;
   logic [FADE_BITS:0]      trial_sub;
   logic                    fits;

   assign last      = (cnt_ff == '0);
   assign trial     = {rem_ff, prod_ff[PW-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign fits      = (trial >= {1'b0, div_ff});

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         UNIT_IDLE: begin
            if (cmd.start) begin
               phase_in = cmd.scale ? UNIT_MUL : UNIT_DIV;
            end
         end
         UNIT_MUL: begin
            if (last) begin
               phase_in = UNIT_DIV;
            end
         end
         UNIT_DIV: begin
            if (last) begin
               phase_in = UNIT_IDLE;
            end
         end
         default: phase_in = UNIT_IDLE;
      endcase
   end

   always_comb begin
      done_in  = (phase_ff == UNIT_DIV) && last;
      done     = done_ff;
      quotient = quo_ff;
   end

   always_comb begin
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      unique case (phase_ff)
         UNIT_IDLE: begin
            if (cmd.start) begin
               mcand_in  = PW'(opa);
               mplier_in = opb;
               div_in    = divisor;
               rem_in    = '0;
               if (cmd.scale) begin
                  prod_in = '0;
                  cnt_in  = CW'(FRAME_BITS - 1);
               end else begin
                  prod_in = PW'(opa);
                  cnt_in  = CW'(PW - 1);
               end
            end
         end
         UNIT_MUL: begin
            prod_in   = {prod_ff[PW-2:0], 1'b0} + (mplier_ff[FRAME_BITS-1] ? mcand_ff : '0);
            mplier_in = {mplier_ff[FRAME_BITS-2:0], 1'b0};
            cnt_in    = last ? CW'(PW - 1) : cnt_ff - CW'(1);
         end
         UNIT_DIV: begin
            rem_in  = fits ? trial_sub[FADE_BITS-1:0] : trial[FADE_BITS-1:0];
            prod_in = {prod_ff[PW-2:0], 1'b0};
            quo_in  = {quo_ff[COLOR_BITS-2:0], fits};
            if (!last) begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= UNIT_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

endmodule

`default_nettype wire

FILE: bench/tb_rgb_random_color_crossfade_core.sv
`timescale 1ns / 1ps

module tb_rgb_random_color_crossfade_core;
   import rgbcf_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       lit;
      logic       taken;
      logic       rejected;
   } lamp_result_type;

   typedef enum logic {
      ROW_TICK,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_ADDR_BITS-1:0] csr_index;
      logic [CSR_DATA_BITS-1:0] csr_value;
      logic                     enable;
      logic [7:0]               red;
      logic [7:0]               green;
      logic [7:0]               blue;
      logic                     typed;
      lamp_result_type          want;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_BITS-1:0]      rsp_tdata;

   // lamp model state; limits indexed red, green, blue
   int fade_cfg = FADE_RESET;
   int limit_cfg[3] = '{LIMIT_RESET, LIMIT_RESET, LIMIT_RESET};
   int start_rgb[3] = '{0, 0, 0};
   int target_rgb[3] = '{0, 0, 0};
   int duty_rgb[3] = '{0, 0, 0};
   int frame_pos = 0;
   bit lit_now = 0;

   lamp_result_type pending_duties[$];
   stim_row_type    directed_rows[$];
   int              errors = 0;
   int              results_seen = 0;
   int              ready_hold = 0;
   bit              hold_done = 0;
   bit              quiet = 0;

   rgb_random_color_crossfade_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   function automatic int abs_gap(int a, int c);
      return a >= c ? a - c : c - a;
   endfunction

   // brightness window on the total, then spread of at least one channel around the mean
   function automatic bit color_passes(int r, int g, int b);
      int total;
      int avg;
      total = r + g + b;
      if (total <= limit_cfg[1] || total > 2 * limit_cfg[1])
         return 0;
      avg = total / 3;
      return abs_gap(avg, r) > limit_cfg[0] / 2 || abs_gap(avg, g) > limit_cfg[1] / 2 ||
             abs_gap(avg, b) > limit_cfg[2] / 2;
   endfunction

   function automatic int fade_level(int from, int to, int pos, int len);
      if (to >= from)
         return (from + (to - from) * pos / len) & 255;
      return (from - (from - to) * pos / len) & 255;
   endfunction

   function automatic lamp_result_type advance_lamp(bit en, int r, int g, int b);
      lamp_result_type res;
      int              len;
      int              cand[3];
      int              i;
      bit              go;
      res = '0;
      go = 1;
      len = (fade_cfg == 0) ? 1 : fade_cfg;
      cand[0] = r;
      cand[1] = g;
      cand[2] = b;
      if (en) begin
         if (!lit_now || frame_pos >= len) begin
            if (color_passes(r, g, b)) begin
               for (i = 0; i < 3; i++) begin
                  start_rgb[i] = target_rgb[i];
                  target_rgb[i] = cand[i];
               end
               frame_pos = 0;
               lit_now = 1;
               res.taken = 1'b1;
            end else begin
               res.rejected = 1'b1;
               go = 0;
            end
         end
         if (go) begin
            for (i = 0; i < 3; i++)
               duty_rgb[i] = fade_level(start_rgb[i], target_rgb[i], frame_pos, len);
            frame_pos = (frame_pos + 1) & 16'hFFFF;
         end
      end else if (lit_now) begin
         for (i = 0; i < 3; i++) begin
            target_rgb[i] = 0;
            duty_rgb[i] = 0;
         end
         lit_now = 0;
      end
      res.red = 8'(duty_rgb[0]);
      res.green = 8'(duty_rgb[1]);
      res.blue = 8'(duty_rgb[2]);
      res.lit = lit_now;
      return res;
   endfunction

   function automatic stim_row_type tick_row(bit en, int r, int g, int b);
      stim_row_type row;
      row = '0;
      row.kind = ROW_TICK;
      row.enable = en;
      row.red = 8'(r);
      row.green = 8'(g);
      row.blue = 8'(b);
      return row;
   endfunction

   function automatic stim_row_type checked_row(bit en, int r, int g, int b, int wr, int wg,
                                                int wb, bit lit, bit taken, bit rejected);
      stim_row_type row;
      row = tick_row(en, r, g, b);
      row.typed = 1'b1;
      row.want.red = 8'(wr);
      row.want.green = 8'(wg);
      row.want.blue = 8'(wb);
      row.want.lit = lit;
      row.want.taken = taken;
      row.want.rejected = rejected;
      return row;
   endfunction

   function automatic stim_row_type write_row(logic [CSR_ADDR_BITS-1:0] idx, int value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.csr_index = idx;
      row.csr_value = CSR_DATA_BITS'(value);
      return row;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   task automatic send_tick(bit en, int r, int g, int b, bit typed, lamp_result_type want);
      lamp_result_type predicted;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata <= {{(REQ_BITS - 25){1'b0}}, b[7:0], g[7:0], r[7:0], en};
      do @(posedge clock); while (!req_tready);
      predicted = advance_lamp(en, r, g, b);
      pending_duties.push_back(typed ? want : predicted);
   endtask

   // drop valid and wait for every outstanding tick to come back
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 0;
      while (pending_duties.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_BITS-1:0] idx, int value);
      @(negedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         REG_FADE_FRAMES: fade_cfg = value & 16'hFFFF;
         REG_RED_LIMIT:   limit_cfg[0] = value & 255;
         REG_GREEN_LIMIT: limit_cfg[1] = value & 255;
         REG_BLUE_LIMIT:  limit_cfg[2] = value & 255;
         default: ;
      endcase
   endtask

   task automatic configure(int fade, int red, int green, int blue);
      write_reg(REG_FADE_FRAMES, fade);
      write_reg(REG_RED_LIMIT, red);
      write_reg(REG_GREEN_LIMIT, green);
      write_reg(REG_BLUE_LIMIT, blue);
   endtask

   // mostly colors inside the brightness window, some plain noise
   task automatic pick_candidate(output int r, output int g, output int b);
      int total;
      int tries;
      if ($urandom_range(0, 2) != 0 && limit_cfg[1] != 0) begin
         for (tries = 0; tries < 40; tries++) begin
            total = $urandom_range(limit_cfg[1] + 1, 2 * limit_cfg[1]);
            if (total > 765)
               total = 765;
            r = $urandom_range(0, total > 255 ? 255 : total);
            g = $urandom_range(0, (total - r) > 255 ? 255 : total - r);
            b = total - r - g;
            if (b <= 255 && color_passes(r, g, b))
               return;
         end
      end
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (ready_hold > 0) begin
         rsp_tready <= 0;
         ready_hold--;
      end else if (!hold_done && results_seen >= 120) begin
         // long back-pressure so the core backs up onto its input
         hold_done = 1;
         ready_hold = 399;
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         ready_hold = $urandom_range(0, 7);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin : rsp_check
      lamp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_duties.size() == 0) begin
            errors++;
            $display("%0t unexpected transaction: expected none actual %h", $time, rsp_tdata);
         end else begin
            want = pending_duties.pop_front();
            check_field("red_duty", int'(want.red), int'(rsp_tdata[7:0]));
            check_field("green_duty", int'(want.green), int'(rsp_tdata[15:8]));
            check_field("blue_duty", int'(want.blue), int'(rsp_tdata[23:16]));
            check_field("lamp_lit", int'(want.lit), int'(rsp_tdata[24]));
            check_field("target_taken", int'(want.taken), int'(rsp_tdata[25]));
            check_field("candidate_rejected", int'(want.rejected), int'(rsp_tdata[26]));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("rgb_random_color_crossfade_core test failed");
      $finish;
   end

   initial begin
      int           i;
      int           phase;
      int           count;
      int           r;
      int           g;
      int           b;
      stim_row_type row;
      reset = 1;
      csr_we = 0;
      csr_addr = '0;
      csr_wdata = '0;
      req_tvalid = 0;
      req_tdata = '0;
      rsp_tready = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // off while dark, out-of-window candidates, first light-up
      directed_rows.push_back(checked_row(0, 255, 255, 255, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(checked_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      directed_rows.push_back(checked_row(1, 255, 255, 255, 0, 0, 0, 0, 0, 1));
      directed_rows.push_back(checked_row(1, 255, 0, 0, 0, 0, 0, 0, 0, 1));
      directed_rows.push_back(checked_row(1, 255, 1, 0, 0, 0, 0, 1, 1, 0));
      directed_rows.push_back(tick_row(1, 17, 3, 200));
      directed_rows.push_back(tick_row(1, 0, 0, 0));
      directed_rows.push_back(checked_row(0, 5, 5, 5, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(checked_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // zero fade length behaves as one tick
      directed_rows.push_back(write_row(REG_FADE_FRAMES, 0));
      directed_rows.push_back(checked_row(1, 0, 255, 1, 0, 0, 0, 1, 1, 0));
      directed_rows.push_back(checked_row(1, 1, 0, 255, 0, 255, 1, 1, 1, 0));
      directed_rows.push_back(checked_row(1, 0, 0, 0, 0, 255, 1, 1, 0, 1));
      // zero green limit rejects everything
      directed_rows.push_back(write_row(REG_GREEN_LIMIT, 0));
      directed_rows.push_back(checked_row(1, 255, 255, 255, 0, 255, 1, 1, 0, 1));
      directed_rows.push_back(checked_row(1, 1, 1, 1, 0, 255, 1, 1, 0, 1));
      directed_rows.push_back(write_row(REG_GREEN_LIMIT, 1));
      directed_rows.push_back(write_row(REG_RED_LIMIT, 1));
      directed_rows.push_back(write_row(REG_BLUE_LIMIT, 1));
      directed_rows.push_back(tick_row(1, 2, 0, 0));
      directed_rows.push_back(tick_row(1, 1, 1, 0));
      directed_rows.push_back(tick_row(1, 0, 1, 1));
      directed_rows.push_back(write_row(REG_RED_LIMIT, 0));
      directed_rows.push_back(write_row(REG_BLUE_LIMIT, 0));
      directed_rows.push_back(write_row(REG_GREEN_LIMIT, 255));
      directed_rows.push_back(tick_row(1, 128, 128, 1));
      directed_rows.push_back(write_row(REG_FADE_FRAMES, 65535));
      directed_rows.push_back(tick_row(1, 255, 1, 0));
      directed_rows.push_back(tick_row(0, 0, 0, 0));
      directed_rows.push_back(tick_row(1, 0, 255, 1));
      directed_rows.push_back(tick_row(1, 200, 40, 90));
      directed_rows.push_back(tick_row(1, 255, 255, 255));

      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            settle();
            write_reg(row.csr_index, int'(row.csr_value));
         end else begin
            send_tick(row.enable, int'(row.red), int'(row.green), int'(row.blue), row.typed,
                      row.want);
         end
      end

      for (phase = 0; phase < 10; phase++) begin
         settle();
         if (phase == 9)
            quiet = 1;
         case (phase)
            0: configure(1, 255, 255, 255);
            1: configure(0, $urandom_range(0, 255), $urandom_range(1, 255),
                         $urandom_range(0, 255));
            2: configure(65535, 255, 255, 255);
            3: configure(3, 255, 0, 255);
            4: configure($urandom_range(1, 12), 1, 1, 1);
            default: configure($urandom_range(1, 12), $urandom_range(0, 255),
                               $urandom_range(1, 255), $urandom_range(0, 255));
         endcase
         count = (phase == 3) ? 12 : 43;
         repeat (count) begin
            pick_candidate(r, g, b);
            send_tick($urandom_range(0, 9) != 0, r, g, b, 0, '0);
         end
      end

      settle();
      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("rgb_random_color_crossfade_core test passed");
      else
         $display("rgb_random_color_crossfade_core test failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/rgbcf_pkg.sv
rtl/core/rgbcf_serial_unit.sv
rtl/core/rgb_random_color_crossfade_core.sv
bench/tb_rgb_random_color_crossfade_core.sv
